@@ hw/rtl/dq_pkg.sv @@
// Types and codes shared by the deque with running aggregates.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 7;

  localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_BACK   = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]       entry_total;
    logic signed [DATA_W-1:0] total_sum;
    logic signed [DATA_W-1:0] smallest;
    logic signed [DATA_W-1:0] largest;
    logic                     is_empty;
    logic                     rejected;
  } out_item_t;

  // control of the shared min/max compare unit
  typedef struct packed {
    logic clear;
    logic load;
    logic cmp;
  } mm_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/dq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/dq_minmax.sv @@
// Shared compare unit holding the running minimum and maximum.
`timescale 1ns / 1ps
`default_nettype none
module dq_minmax (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dq_pkg::mm_ctrl_t                  ctrl,
  input  wire logic signed [dq_pkg::DATA_W-1:0]  value,
  output logic signed [dq_pkg::DATA_W-1:0]       min_o,
  output logic signed [dq_pkg::DATA_W-1:0]       max_o
);

  import dq_pkg::*;

  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctrl.clear) begin
      min_nxt = '0;
      max_nxt = '0;
    end else if (ctrl.load) begin
      min_nxt = value;
      max_nxt = value;
    end else if (ctrl.cmp) begin
      if (value < min_r) min_nxt = value;
      if (value > max_r) max_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign min_o = min_r;
  assign max_o = max_r;

endmodule
`default_nettype wire

@@ hw/rtl/deque_with_running_aggregates_core.sv @@
// Top level: bounded deque of signed values with running count, sum, min and max.
// Push: result valid the cycle after accept; pushes can follow one per cycle while the output is not stalled.
// Pop: ST_POP reads the removed entry, then ST_SCAN rescans the n entries left (if any)
//   through the RAM read port and one compare unit, one entry per cycle; the result
//   is valid once the scan ends; no new item is taken until the block is back in ST_IDLE.
// Synchronous active-low reset empties the deque; sum, min and max read 0.
`timescale 1ns / 1ps
`default_nettype none
module deque_with_running_aggregates_core #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dq_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dq_pkg::out_item_t      out_data
);

  import dq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [PW-1:0]            front_r, front_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]            off_r, off_nxt;
  logic [CW-1:0]            got_r, got_nxt;
  logic                     rej_r, rej_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     accept;
  logic [CW-1:0]            ofs;
  logic [PW:0]              slot_sum;
  logic [PW-1:0]            slot;
  logic [PW-1:0]            front_dec;
  logic [PW-1:0]            front_inc;
  logic                     wr_en;
  logic [PW-1:0]            wr_addr;
  logic [PW-1:0]            rd_addr;
  logic [DATA_W-1:0]        rd_data;
  mm_ctrl_t                 mm_ctrl;
  logic signed [DATA_W-1:0] mm_value;
  logic signed [DATA_W-1:0] cur_min;
  logic signed [DATA_W-1:0] cur_max;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // ring slot of an offset from the front
  always_comb begin
    case (state_r)
      ST_IDLE: ofs = (in_data.mode == MODE_POP_BACK) ? count_r - 1'b1 : count_r;
      ST_SCAN: ofs = off_r;
      default: ofs = '0;
    endcase
    slot_sum = {1'b0, front_r} + {1'b0, ofs[PW-1:0]};
    if (slot_sum >= DEPTH_W) begin
      slot_sum = slot_sum - DEPTH_W;
    end
    slot = slot_sum[PW-1:0];
  end

  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign front_inc = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    off_nxt       = off_r;
    got_nxt       = got_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = slot;
    rd_addr       = slot;
    mm_ctrl       = '0;
    mm_value      = in_data.value;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rej_nxt = 1'b0;
          if (in_data.mode == MODE_PUSH_BACK || in_data.mode == MODE_PUSH_FRONT) begin
            out_valid_nxt = 1'b1;
            if (count_r == FULL_CNT) begin
              rej_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;
              if (in_data.mode == MODE_PUSH_FRONT) begin
                wr_addr   = front_dec;
                front_nxt = front_dec;
              end
              count_nxt = count_r + 1'b1;
              sum_nxt   = sum_r + in_data.value;
              if (count_r == '0) mm_ctrl.load = 1'b1;
              else               mm_ctrl.cmp  = 1'b1;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            if (in_data.mode == MODE_POP_FRONT) begin
              rd_addr   = front_r;
              front_nxt = front_inc;
            end
            count_nxt = count_r - 1'b1;
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        // removed entry on rd_data; start the rescan at the front
        sum_nxt = sum_r - $signed(rd_data);
        rd_addr = front_r;
        if (count_r == '0) begin
          sum_nxt       = '0;
          mm_ctrl.clear = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          off_nxt   = CW'(1);
          got_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mm_value = $signed(rd_data);
        if (got_r == '0) mm_ctrl.load = 1'b1;
        else             mm_ctrl.cmp  = 1'b1;
        off_nxt = off_r + 1'b1;
        got_nxt = got_r + 1'b1;
        if (got_r == count_r - 1'b1) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      off_r       <= '0;
      got_r       <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      off_r       <= off_nxt;
      got_r       <= got_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dq_minmax u_minmax (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mm_ctrl),
    .value (mm_value),
    .min_o (cur_min),
    .max_o (cur_max)
  );

  // state holds while a result waits, so the payload is read straight from it
  assign out_valid            = out_valid_r;
  assign out_data.entry_total = ENTRY_W'(count_r);
  assign out_data.total_sum   = sum_r;
  assign out_data.smallest    = cur_min;
  assign out_data.largest     = cur_max;
  assign out_data.is_empty    = (count_r == '0);
  assign out_data.rejected    = rej_r;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the deque with running count, sum, min and max.
`timescale 1ns / 1ps
module testbench;
  import dq_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_OPS = 450;
  localparam int SETTLE_CYCLES = 80;

  class deque_shadow;
    logic signed [DATA_W-1:0] slots[DEPTH];
    logic signed [DATA_W-1:0] sum, lo, hi;
    int head, fill;
    out_item_t pending_reports[$];
    int errors, results_seen, refused_pushes, empty_pops, pushes, pops;

    function new();
      head = 0;
      fill = 0;
      sum = '0;
      lo = '0;
      hi = '0;
      errors = 0;
      results_seen = 0;
      refused_pushes = 0;
      empty_pops = 0;
      pushes = 0;
      pops = 0;
    endfunction

    function void note_operation(in_item_t op);
      out_item_t rpt;
      logic signed [DATA_W-1:0] v;
      int slot;
      logic refused;
      refused = 1'b0;
      if (op.mode == MODE_PUSH_BACK || op.mode == MODE_PUSH_FRONT) begin
        pushes++;
        if (fill >= DEPTH) begin
          refused = 1'b1;
          refused_pushes++;
        end else begin
          if (op.mode == MODE_PUSH_BACK) begin
            slot = (head + fill) % DEPTH;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slot = head;
          end
          slots[slot] = op.value;
          if (fill == 0) begin
            lo = op.value;
            hi = op.value;
          end else begin
            if (op.value < lo) lo = op.value;
            if (op.value > hi) hi = op.value;
          end
          sum = sum + op.value;
          fill++;
        end
      end else if (fill == 0) begin
        pops++;
        empty_pops++;
      end else begin
        pops++;
        if (op.mode == MODE_POP_FRONT) begin
          slot = head;
          head = (head + 1) % DEPTH;
        end else begin
          slot = (head + fill - 1) % DEPTH;
        end
        sum = sum - slots[slot];
        fill--;
        lo = '0;
        hi = '0;
        if (fill == 0) sum = '0;
        for (int i = 0; i < fill; i++) begin
          v = slots[(head + i) % DEPTH];
          if (i == 0 || v < lo) lo = v;
          if (i == 0 || v > hi) hi = v;
        end
      end
      rpt.entry_total = ENTRY_W'(fill);
      rpt.total_sum = sum;
      rpt.smallest = lo;
      rpt.largest = hi;
      rpt.is_empty = (fill == 0);
      rpt.rejected = refused;
      pending_reports.push_back(rpt);
    endfunction

    function void compare_field(string name, logic signed [DATA_W-1:0] want,
                                logic signed [DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_reports.size() == 0) begin
        $error("result item arrived with none outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("entry_total", want.entry_total, got.entry_total);
      compare_field("total_sum", want.total_sum, got.total_sum);
      compare_field("smallest", want.smallest, got.smallest);
      compare_field("largest", want.largest, got.largest);
      compare_field("is_empty", want.is_empty, got.is_empty);
      compare_field("rejected", want.rejected, got.rejected);
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  deque_shadow board = new();
  bit send_burst;
  bit take_burst;
  bit long_hold_done;
  int sent;

  deque_with_running_aggregates_core #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_item_t make_op(logic [1:0] mode, logic signed [DATA_W-1:0] value);
    in_item_t op;
    op.mode = mode;
    op.value = value;
    return op;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return DATA_W'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t pick_op(int push_pct);
    logic [1:0] mode;
    if ($urandom_range(0, 99) < push_pct) begin
      mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    end else begin
      mode = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
    end
    return make_op(mode, pick_value());
  endfunction

  task automatic send_item(in_item_t op);
    int gap;
    if (sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
    in_data <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_operation(op);
    sent++;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int phase_push_pct[4];
    phase_push_pct = '{80, 50, 15, 80};
    sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pops, extreme values, wrapping sum, both ends
    send_item(make_op(MODE_POP_FRONT, 32'sh1234_5678));
    send_item(make_op(MODE_POP_BACK, 32'sh1234_5678));
    send_item(make_op(MODE_PUSH_BACK, 32'sh7FFF_FFFF));
    send_item(make_op(MODE_PUSH_BACK, 32'sh7FFF_FFFF));
    send_item(make_op(MODE_PUSH_FRONT, 32'sh8000_0000));
    send_item(make_op(MODE_PUSH_FRONT, -32'sd1));
    send_item(make_op(MODE_PUSH_BACK, 32'sd0));
    send_item(make_op(MODE_POP_FRONT, 32'shFFFF_FFFF));
    send_item(make_op(MODE_POP_BACK, 32'sh0));
    send_item(make_op(MODE_POP_FRONT, 32'sh5555_5555));
    send_item(make_op(MODE_POP_BACK, 32'shAAAA_AAAA));
    send_item(make_op(MODE_POP_BACK, 32'sh0));
    send_item(make_op(MODE_POP_FRONT, 32'sh0));
    send_item(make_op(MODE_PUSH_FRONT, 32'sd5));
    send_item(make_op(MODE_PUSH_FRONT, 32'sd5));
    send_item(make_op(MODE_POP_BACK, 32'sh0));
    send_item(make_op(MODE_POP_FRONT, 32'sh0));
    send_item(make_op(MODE_PUSH_BACK, 32'sh8000_0000));
    send_item(make_op(MODE_POP_BACK, 32'sh0));

    // fill up, hover, drain, refill
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < RANDOM_OPS / 4 + (p == 3 ? RANDOM_OPS % 4 : 0); i++) begin
        send_item(pick_op(phase_push_pct[p]));
      end
    end
    in_valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d pushes (%0d refused on a full store), %0d pops (%0d on an empty store)",
             board.pushes, board.refused_pushes, board.pops, board.empty_pops);
    $display("%0d result items checked, %0d mismatches", board.results_seen, board.errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("[deque_with_running_aggregates_core] OK");
    end else begin
      $display("[deque_with_running_aggregates_core] ERROR");
    end
    $finish;
  end

  initial begin
    int hold;
    int taken;
    taken = 0;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
      hold = take_burst ? 0 : $urandom_range(0, 12);
      // one long back-pressure stretch so a result waits and the block stalls its input
      if (!long_hold_done && taken >= 150) begin
        hold = 400;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      board.check_report(out_data);
      taken++;
    end
  end

  initial begin
    #(2_000_000);
    $display("[deque_with_running_aggregates_core] ERROR");
    $finish;
  end

endmodule
